@@ sv/x128_pkg.sv @@
// Package for the xoroshiro128++ generator: operation codes, constants and
// the multiplier request type. No dependencies.
package x128_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned BoundW = 31;

	localparam logic [63:0] Golden = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] Silver = 64'h6A09E667F3BCC909;
	localparam logic [63:0] MixMul1 = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MixMul2 = 64'h94D049BB133111EB;
	localparam logic [31:0] PosMulX = 32'd3129871;
	localparam logic [63:0] PosMulZ = 64'd116129781;
	localparam logic [63:0] PosMulH = 64'd42317861;
	localparam logic [63:0] PosMulL = 64'd11;

	localparam logic [0:0] RegFactoryLow = 1'b0;
	localparam logic [0:0] RegFactoryHigh = 1'b1;

	typedef enum logic [2:0] {
		KIND_SEED = 3'd0,
		KIND_RAW = 3'd1,
		KIND_POS = 3'd2,
		KIND_DRAW64 = 3'd3,
		KIND_DRAW53 = 3'd4,
		KIND_DRAW24 = 3'd5,
		KIND_BOUNDED = 3'd6,
		KIND_FORK = 3'd7
	} kind_t;

	// One multiply request to the shared unit
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

endpackage

@@ sv/xoroshiro128pp_generator.sv @@
// xoroshiro128++ generator. Draws (64/53/24-bit), forks (two draws) and raw seeds need no
// multiplier; a Stafford seed makes four passes and a positional seed five passes through the
// shared 3-step multiplier; a bounded draw takes one draw per test plus a bit-serial
// remainder when the low product falls below the bound. One request at a time, the next
// taken once the result has been accepted.
// Reset loads the golden/silver state and clears the factory registers. Uses x128_mul.
module xoroshiro128pp_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           kind,
	input  logic signed [63:0]   seed_value,
	input  logic [63:0]          seed_high_word,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic [30:0]          bound,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          value,
	output logic [63:0]          value_high,
	output logic [30:0]          bounded_value,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [x128_pkg::WordW-1:0] cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MUL   = 10'b0000000010,
		ST_WAIT  = 10'b0000000100,
		ST_DRAW  = 10'b0000001000,
		ST_REM   = 10'b0000010000,
		ST_LOAD  = 10'b0000100000,
		ST_OUT   = 10'b0001000000,
		ST_NEXT  = 10'b0010000000,
		ST_BTEST = 10'b0100000000,
		ST_FORK2 = 10'b1000000000
	} state_t;

	state_t      state_q;
	logic [2:0]  kind_q;
	logic [3:0]  phase_q;
	logic [63:0] lo_q, hi_q, fac_lo_q, fac_hi_q;
	logic [63:0] t_q, v_q, w_q;
	logic [30:0] bnd_q;
	logic [31:0] lim_q, rem_q;
	logic [5:0]  cnt_q;
	logic        chk_q;
	logic [63:0] val_q, valh_q;
	logic [30:0] bval_q;

	logic              mul_start;
	x128_pkg::mul_req_t mul_req;
	logic              mul_done;
	logic [63:0]       mul_p;

	logic [63:0] drw_r, drw_lo, drw_hi, b_x;
	logic [63:0] bmul;
	logic [31:0] rem_try;

	x128_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .req(mul_req),
		.done(mul_done), .product(mul_p)
	);

	// One xoroshiro128++ step from the current state
	assign b_x = hi_q ^ lo_q;
	assign drw_r = {(lo_q + hi_q)} << 17 | (lo_q + hi_q) >> 47;
	assign drw_lo = ({lo_q[14:0], lo_q[63:15]}) ^ b_x ^ (b_x << 21);
	assign drw_hi = {b_x[35:0], b_x[63:36]};
	assign bmul = {32'd0, drw_r[31:0] + lo_q[31:0]} * {33'd0, bnd_q};
	assign rem_try = {rem_q[30:0], lim_q[31]} - {1'b0, bnd_q};

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign value = val_q;
	assign value_high = valh_q;
	assign bounded_value = bval_q;

	// Factory registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fac_lo_q <= 64'd0;
			fac_hi_q <= 64'd0;
		end else if (cfg_we) begin
			if (cfg_index == x128_pkg::RegFactoryLow) fac_lo_q <= cfg_data[63:0];
			else fac_hi_q <= cfg_data[63:0];
		end
	end

	// Multiply requests per phase of seeding
	always_comb begin
		mul_start = 1'b0;
		mul_req.a = v_q;
		mul_req.b = x128_pkg::MixMul1;
		if (state_q == ST_MUL) begin
			mul_start = 1'b1;
			priority case (phase_q)
				4'd0: mul_req = '{a: v_q ^ (v_q >> 30), b: x128_pkg::MixMul1};
				4'd1: mul_req = '{a: v_q ^ (v_q >> 27), b: x128_pkg::MixMul2};
				4'd2: mul_req = '{a: w_q ^ (w_q >> 30), b: x128_pkg::MixMul1};
				4'd3: mul_req = '{a: w_q ^ (w_q >> 27), b: x128_pkg::MixMul2};
				4'd4: mul_req = '{a: {32'd0, v_q[31:0]},
					b: {32'd0, x128_pkg::PosMulX}};
				4'd5: mul_req = '{a: w_q, b: x128_pkg::PosMulZ};
				4'd6: mul_req = '{a: v_q, b: v_q};
				4'd7: mul_req = '{a: w_q, b: x128_pkg::PosMulH};
				default: mul_req = '{a: v_q, b: x128_pkg::PosMulL};
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lo_q <= x128_pkg::Golden;
			hi_q <= x128_pkg::Silver;
			phase_q <= 4'd0;
			chk_q <= 1'b0;
			kind_q <= 3'd0;
			bnd_q <= 31'd0;
			t_q <= 64'd0;
			v_q <= 64'd0;
			w_q <= 64'd0;
			lim_q <= 32'd0;
			rem_q <= 32'd0;
			cnt_q <= 6'd0;
			val_q <= 64'd0;
			valh_q <= 64'd0;
			bval_q <= 31'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					kind_q <= kind;
					bnd_q <= bound;
					val_q <= 64'd0;
					valh_q <= 64'd0;
					bval_q <= 31'd0;
					unique case (x128_pkg::kind_t'(kind))
						x128_pkg::KIND_SEED: begin
							v_q <= seed_value ^ x128_pkg::Silver;
							w_q <= (seed_value ^ x128_pkg::Silver) + x128_pkg::Golden;
							phase_q <= 4'd0;
							state_q <= ST_MUL;
						end
						x128_pkg::KIND_RAW: begin
							v_q <= seed_value;
							w_q <= seed_high_word;
							state_q <= ST_LOAD;
						end
						x128_pkg::KIND_POS: begin
							v_q <= {32'd0, pos_x};
							w_q <= {{32{pos_z[31]}}, pos_z};
							t_q <= {{32{pos_y[31]}}, pos_y};
							phase_q <= 4'd4;
							state_q <= ST_MUL;
						end
						x128_pkg::KIND_BOUNDED: state_q <= ST_BTEST;
						default: state_q <= ST_DRAW;
					endcase
				end
				ST_MUL: state_q <= ST_WAIT;
				ST_WAIT: if (mul_done) begin
					state_q <= ST_MUL;
					phase_q <= phase_q + 4'd1;
					priority case (phase_q)
						4'd0: v_q <= mul_p;
						4'd1: begin
							v_q <= mul_p ^ (mul_p >> 31);
						end
						4'd2: w_q <= mul_p;
						4'd3: begin
							w_q <= mul_p ^ (mul_p >> 31);
							state_q <= ST_LOAD;
						end
						4'd4: t_q <= t_q ^ {{32{mul_p[31]}}, mul_p[31:0]};
						4'd5: begin
							v_q <= t_q ^ mul_p;
							w_q <= t_q ^ mul_p;
						end
						4'd6: w_q <= mul_p;
						4'd7: t_q <= mul_p;
						default: begin
							t_q <= t_q + mul_p;
							v_q <= $signed(t_q + mul_p) >>> 16;
							w_q <= fac_hi_q;
							state_q <= ST_NEXT;
						end
					endcase
				end
				ST_NEXT: begin
					v_q <= v_q ^ fac_lo_q;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if ((v_q | w_q) == 64'd0) begin
						lo_q <= x128_pkg::Golden;
						hi_q <= x128_pkg::Silver;
					end else begin
						lo_q <= v_q;
						hi_q <= w_q;
					end
					state_q <= ST_OUT;
				end
				ST_DRAW: begin
					lo_q <= drw_lo;
					hi_q <= drw_hi;
					unique case (x128_pkg::kind_t'(kind_q))
						x128_pkg::KIND_DRAW53: val_q <= (drw_r + lo_q) >> 11;
						x128_pkg::KIND_DRAW24: val_q <= (drw_r + lo_q) >> 40;
						x128_pkg::KIND_FORK: begin
							val_q <= drw_r + lo_q;
							state_q <= ST_FORK2;
						end
						default: val_q <= drw_r + lo_q;
					endcase
					if (kind_q != x128_pkg::KIND_FORK) state_q <= ST_OUT;
				end
				ST_FORK2: begin
					lo_q <= drw_lo;
					hi_q <= drw_hi;
					if ((val_q | (drw_r + lo_q)) == 64'd0) begin
						val_q <= x128_pkg::Golden;
						valh_q <= x128_pkg::Silver;
					end else begin
						valh_q <= drw_r + lo_q;
					end
					state_q <= ST_OUT;
				end
				ST_BTEST: begin
					// one draw, keep or reject on the low product bits
					lo_q <= drw_lo;
					hi_q <= drw_hi;
					bval_q <= bmul[62:32];
					if (!chk_q) begin
						if (bmul[31:0] < {1'b0, bnd_q}) begin
							lim_q <= 32'd0 - {1'b0, bnd_q};
							rem_q <= 32'd0;
							cnt_q <= 6'd32;
							w_q <= {32'd0, bmul[31:0]};
							state_q <= ST_REM;
						end else begin
							state_q <= ST_OUT;
						end
					end else if (bmul[31:0] >= lim_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_REM: begin
					// restoring remainder, one bit a cycle
					if (cnt_q == 6'd0) begin
						lim_q <= rem_q;
						if (w_q[31:0] < rem_q) begin
							chk_q <= 1'b1;
							state_q <= ST_BTEST;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						rem_q <= rem_try[31] ? {rem_q[30:0], lim_q[31]} : rem_try;
						lim_q <= {lim_q[30:0], 1'b0};
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_OUT: if (!out_stall) begin
					chk_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A bounded result stays below its bound
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind_q == x128_pkg::KIND_BOUNDED && bnd_q != 31'd0)
		|-> (bval_q < bnd_q)) else $error("bounded result out of range");
	// The state never goes all-zero
	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(lo_q | hi_q) != 64'd0) else $error("state all zero");
	// Results appear only for a request in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result while idle");

endmodule

@@ sv/x128_mul.sv @@
// Shared 64x64 (low 64 bits) multiplier, built from three 32x32 partial products
// taken in turn. Depends on x128_pkg.
module x128_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  x128_pkg::mul_req_t  req,
	output logic                done,
	output logic [63:0]         product
);

	logic [1:0]  step_q;
	logic [31:0] al_q, ah_q, bl_q, bh_q;
	logic [63:0] acc_q;
	logic [31:0] cross_q;
	logic [63:0] pp;
	logic [31:0] mul_a, mul_b;

	// Pick the partial product for this step
	always_comb begin
		unique case (step_q)
			2'd1: begin
				mul_a = al_q;
				mul_b = bl_q;
			end
			2'd2: begin
				mul_a = al_q;
				mul_b = bh_q;
			end
			default: begin
				mul_a = ah_q;
				mul_b = bl_q;
			end
		endcase
	end

	assign pp = {32'd0, mul_a} * {32'd0, mul_b};

	// Step through low, cross terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
		end else if (start) begin
			step_q <= 2'd1;
		end else if (step_q != 2'd0) begin
			step_q <= (step_q == 2'd3) ? 2'd0 : step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			al_q <= req.a[31:0];
			ah_q <= req.a[63:32];
			bl_q <= req.b[31:0];
			bh_q <= req.b[63:32];
			cross_q <= 32'd0;
		end else if (step_q == 2'd1) begin
			acc_q <= pp;
		end else if (step_q == 2'd2) begin
			cross_q <= pp[31:0];
		end else if (step_q == 2'd3) begin
			acc_q <= {acc_q[63:32] + cross_q + pp[31:0], acc_q[31:0]};
		end
	end

	assign done = (step_q == 2'd0) && !start;
	assign product = acc_q;

endmodule

@@ bench/tb_xoroshiro128pp_generator.sv @@
// Testbench for the xoroshiro128++ generator: drives seed, draw, bounded and fork
// requests, predicts every result and compares it field by field.
// Depends on x128_pkg and the xoroshiro128pp_generator RTL.
module tb_xoroshiro128pp_generator;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		x128_pkg::kind_t kind;
		logic [63:0] seed_value;
		logic [63:0] seed_high_word;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [30:0] bound;
	} request_t;

	typedef struct {
		logic [63:0] value;
		logic [63:0] value_high;
		logic [30:0] bounded_value;
	} draw_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] kind = '0;
	logic signed [63:0] seed_value = '0;
	logic [63:0] seed_high_word = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic [30:0] bound = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] value;
	logic [63:0] value_high;
	logic [30:0] bounded_value;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = x128_pkg::RegFactoryLow;
	logic [63:0] cfg_data = '0;

	request_t pending_requests[$];
	draw_result_t expected_draws[$];
	logic [63:0] gen_lo, gen_hi, fac_lo, fac_hi;
	int errors = 0;
	int unsigned cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;
	int stall_mode = 0;
	// in_stall_seen tells whether the request still on the port was not taken
	logic in_stall_seen = 1'b0;

	xoroshiro128pp_generator u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the generator model by one draw
	function automatic logic [63:0] next_word();
		logic [63:0] a, b, r, s;
		a = gen_lo;
		b = gen_hi;
		s = a + b;
		r = {s[46:0], s[63:47]} + a;
		b = b ^ a;
		gen_lo = {a[14:0], a[63:15]} ^ b ^ (b << 21);
		gen_hi = {b[35:0], b[63:36]};
		return r;
	endfunction

	function automatic logic [63:0] mix13(logic [63:0] v);
		v = (v ^ (v >> 30)) * 64'hBF58476D1CE4E5B9;
		v = (v ^ (v >> 27)) * 64'h94D049BB133111EB;
		return v ^ (v >> 31);
	endfunction

	function automatic void load_state(logic [63:0] lo, logic [63:0] hi);
		if ((lo | hi) == 0) begin
			lo = x128_pkg::Golden;
			hi = x128_pkg::Silver;
		end
		gen_lo = lo;
		gen_hi = hi;
	endfunction

	function automatic logic [63:0] hash_position(logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		logic [31:0] px;
		logic [63:0] h;
		px = x * 32'd3129871;
		h = {{32{px[31]}}, px};
		h ^= {{32{z[31]}}, z} * 64'd116129781;
		h ^= {{32{y[31]}}, y};
		h = h * h * 64'd42317861 + h * 64'd11;
		return {{16{h[63]}}, h[63:16]};
	endfunction

	// Multiply-and-reject draw; a zero bound still consumes one draw
	function automatic logic [30:0] bounded_pick(logic [31:0] b);
		logic [63:0] m;
		logic [63:0] d;
		logic [31:0] lim;
		d = next_word();
		m = {32'b0, d[31:0]} * {32'b0, b};
		if (m[31:0] < b) begin
			lim = (32'd0 - b) % b;
			while (m[31:0] < lim) begin
				d = next_word();
				m = {32'b0, d[31:0]} * {32'b0, b};
			end
		end
		return m[62:32];
	endfunction

	// Predict the result of one accepted request
	function automatic draw_result_t predict_draw(request_t rq);
		draw_result_t res;
		logic [63:0] t;
		res = '{64'd0, 64'd0, 31'd0};
		case (rq.kind)
			x128_pkg::KIND_SEED: begin
				t = rq.seed_value ^ x128_pkg::Silver;
				load_state(mix13(t), mix13(t + x128_pkg::Golden));
			end
			x128_pkg::KIND_RAW: load_state(rq.seed_value, rq.seed_high_word);
			x128_pkg::KIND_POS: load_state(hash_position(rq.pos_x, rq.pos_y, rq.pos_z)
				^ fac_lo, fac_hi);
			x128_pkg::KIND_DRAW64: res.value = next_word();
			x128_pkg::KIND_DRAW53: res.value = next_word() >> 11;
			x128_pkg::KIND_DRAW24: res.value = next_word() >> 40;
			x128_pkg::KIND_BOUNDED: res.bounded_value = bounded_pick({1'b0, rq.bound});
			default: begin
				res.value = next_word();
				res.value_high = next_word();
				if ((res.value | res.value_high) == 0) begin
					res.value = x128_pkg::Golden;
					res.value_high = x128_pkg::Silver;
				end
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// Drive requests in bursts with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall_seen) begin
				// hold
			end else begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					request_t rq;
					rq = pending_requests.pop_front();
					expected_draws.push_back(predict_draw(rq));
					kind <= rq.kind;
					seed_value <= rq.seed_value;
					seed_high_word <= rq.seed_high_word;
					pos_x <= rq.pos_x;
					pos_y <= rq.pos_y;
					pos_z <= rq.pos_z;
					bound <= rq.bound;
					in_valid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else
					in_valid <= 1'b0;
			end
			// Receiver stall pattern
			stall_phase++;
			if (stall_phase % 200 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= (stall_phase % 7) < 3;
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Sample handshake and results at the rising edge
	always @(posedge clk) begin
		cycles++;
		in_stall_seen <= in_valid && in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_draws.size() == 0) begin
				report_mismatch("unexpected result", value, 64'd0);
			end else begin
				draw_result_t w;
				w = expected_draws.pop_front();
				if (value !== w.value) report_mismatch("value", value, w.value);
				if (value_high !== w.value_high)
					report_mismatch("value_high", value_high, w.value_high);
				if (bounded_value !== w.bounded_value)
					report_mismatch("bounded_value", {33'd0, bounded_value},
						{33'd0, w.bounded_value});
			end
		end
		if (cycles > 600000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic request_t random_request();
		request_t rq;
		int sel;
		rq.kind = x128_pkg::kind_t'($urandom_range(0, 7));
		rq.seed_value = {$urandom, $urandom};
		rq.seed_high_word = {$urandom, $urandom};
		rq.pos_x = $urandom;
		rq.pos_y = $urandom;
		rq.pos_z = $urandom;
		sel = $urandom_range(0, 5);
		case (sel)
			0: rq.bound = 31'($urandom_range(0, 3));
			1: rq.bound = 31'(32'h7FFFFFFF - $urandom_range(0, 3));
			2: rq.bound = 31'(32'h40000000 + $urandom_range(0, 1000));
			default: rq.bound = 31'($urandom);
		endcase
		// Draws dominate so the state evolves deeply between reseeds
		if ($urandom_range(0, 9) < 6)
			rq.kind = x128_pkg::kind_t'($urandom_range(3, 7));
		if (rq.kind == x128_pkg::KIND_RAW && $urandom_range(0, 9) == 0) begin
			rq.seed_value = '0;
			rq.seed_high_word = '0;
		end
		return rq;
	endfunction

	function automatic request_t make_request(x128_pkg::kind_t k, logic [63:0] sv,
			logic [63:0] sh, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [30:0] b);
		request_t rq;
		rq = '{k, sv, sh, x, y, z, b};
		return rq;
	endfunction

	task automatic write_factory(logic [63:0] lo, logic [63:0] hi);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= x128_pkg::RegFactoryLow;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= x128_pkg::RegFactoryHigh;
		cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
		fac_lo = lo;
		fac_hi = hi;
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || expected_draws.size() > 0 || in_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		gen_lo = x128_pkg::Golden;
		gen_hi = x128_pkg::Silver;
		fac_lo = 0;
		fac_hi = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: draws from reset state, every kind, field extremes
		pending_requests.push_back(make_request(x128_pkg::KIND_DRAW64, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_DRAW53, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_DRAW24, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_FORK, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_BOUNDED, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_BOUNDED, 0, 0, 0, 0, 0, 1));
		pending_requests.push_back(make_request(x128_pkg::KIND_BOUNDED, 0, 0, 0, 0, 0,
			31'h7FFFFFFF));
		pending_requests.push_back(make_request(x128_pkg::KIND_BOUNDED, 0, 0, 0, 0, 0,
			31'h40000001));
		pending_requests.push_back(make_request(x128_pkg::KIND_SEED, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_SEED, x128_pkg::Silver, 0,
			0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_SEED, '1, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_SEED, 64'h8000000000000000,
			0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_DRAW64, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_RAW, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_DRAW64, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_RAW, '1, '1, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_FORK, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_POS, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_DRAW64, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_POS, 0, 0, 32'h80000000,
			32'h7FFFFFFF, 32'hFFFFFFFF, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_DRAW64, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_POS, 0, 0, '1, 32'h80000000,
			32'h7FFFFFFF, 0));
		pending_requests.push_back(make_request(x128_pkg::KIND_FORK, 0, 0, 0, 0, 0, 0));
		drain();

		// Phases through factory settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_factory('1, '1);
				1: write_factory(0, 0);
				2: write_factory(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
				default: write_factory({$urandom, $urandom}, {$urandom, $urandom});
			endcase
			if (ph == 1)
				pending_requests.push_back(make_request(x128_pkg::KIND_POS, 0, 0, 0, 0, 0,
					0));
			for (int i = 0; i < 220; i++)
				pending_requests.push_back(random_request());
			drain();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
